/* hdl/block_matrix_multiply_core_defines.svh */
// Assertion macros for the checker file of the block matrix multiply core.
// Depends on nothing; included by bmm_checker.sv.
`ifndef BLOCK_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define BLOCK_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BMM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define BMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bmm_pkg.sv */
// Shared types and constants of the block matrix multiply core.
// Depends on nothing; used by the interfaces, the top level, front end, queue and back end.
package bmm_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned BSZ_W       = 5;
  localparam int unsigned OUT_IDX_W   = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 7;
  localparam int unsigned PROD_W      = 2 * VALUE_W;
  localparam int unsigned Q_FRAC      = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [BSZ_W-1:0] BSZ_RESET = 5'd16;

  // Opcodes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_ROW  = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATRIX_DIM = 1'b0,
    CFG_BLOCK_SIZE = 1'b1
  } cfg_idx_e;

  // Commands that survive classification.
  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_ROW  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e               kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic [BSZ_W-1:0] bsz;
  } cfg_t;

endpackage

/* hdl/bmm_intf.sv */
// Handshake channel interfaces of the block matrix multiply core.
// Depends on bmm_pkg for the field widths.
interface bmm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmm_pkg::CFG_IDX_W-1:0]   index;
  logic [bmm_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface bmm_in_if;
  logic                              valid;
  logic                              ready;
  logic [bmm_pkg::OP_W-1:0]          opcode;
  logic [bmm_pkg::IDX_W-1:0]         row_index;
  logic [bmm_pkg::IDX_W-1:0]         col_index;
  logic signed [bmm_pkg::VALUE_W-1:0] value;
  modport source (output valid, opcode, row_index, col_index, value, input ready);
  modport sink   (input valid, opcode, row_index, col_index, value, output ready);
endinterface

interface bmm_out_if;
  logic                               valid;
  logic                               ready;
  logic [bmm_pkg::OUT_IDX_W-1:0]      block_row;
  logic [bmm_pkg::OUT_IDX_W-1:0]      block_col;
  logic signed [bmm_pkg::VALUE_W-1:0] product;
  logic                               saturated;
  logic                               last;
  modport source (output valid, block_row, block_col, product, saturated, last,
                  input ready);
  modport sink   (input valid, block_row, block_col, product, saturated, last,
                  output ready);
endinterface

/* hdl/block_matrix_multiply_core.sv */
// Block matrix multiply core: one block row of C = A * B per compute item.
// Load items are taken by the back end only while it is idle; a compute item occupies the
// single multiply-accumulate unit, one term a cycle, with drain, rounding and hand-off per result,
// and no other command is taken until its last result has been loaded for output.
// Reset sets matrix_dim to 64 and block_size to 16 and empties the queue and the
// result register; the band stores keep whatever they held and need no clearing.
// Depends on bmm_pkg, the channel interfaces, bmm_front, bmm_queue and bmm_back.
module block_matrix_multiply_core #(
  parameter int unsigned MAX_DIM   = 64,
  parameter int unsigned MAX_BLOCK = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmm_cfg_if.sink    cfg_i,
  bmm_in_if.sink     in_i,
  bmm_out_if.source  out_o
);

  // Raw configuration registers, as written.
  logic [bmm_pkg::DIM_W-1:0] dim_q;
  logic [bmm_pkg::BSZ_W-1:0] bsz_q;
  bmm_pkg::cfg_t             cfg_eff;

  // Command path from the front end through the queue to the back end.
  logic          push_valid, push_ready;
  bmm_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  bmm_pkg::cmd_t pop_cmd;

  // Configuration writes are always taken. The user must write only while the block is idle;
  // the block itself does not enforce it; kept to, neither end sees the clamped values change mid-item.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= bmm_pkg::DIM_RESET;
      bsz_q <= bmm_pkg::BSZ_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bmm_pkg::CFG_MATRIX_DIM: dim_q <= cfg_i.data;
        bmm_pkg::CFG_BLOCK_SIZE: bsz_q <= cfg_i.data[bmm_pkg::BSZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Values above the store geometry are clamped to it.
  assign cfg_eff.dim = (int'(dim_q) > MAX_DIM) ? bmm_pkg::DIM_W'(MAX_DIM) : dim_q;
  assign cfg_eff.bsz = (int'(bsz_q) > MAX_BLOCK) ? bmm_pkg::BSZ_W'(MAX_BLOCK) : bsz_q;

  // The front end filters items against the current band geometry, so only
  // commands with work to do take up queue slots.
  bmm_front u_front (
    .in_i        (in_i),
    .cfg_i       (cfg_eff),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  // The queue keeps loads and compute commands in order, so a load that
  // follows a compute item never disturbs the values that item reads.
  bmm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  // The back end owns both band stores and the MAC; its result register lets
  // the next result be built while the previous one waits downstream.
  bmm_back #(
    .MAX_DIM  (MAX_DIM),
    .MAX_BLOCK(MAX_BLOCK)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_eff),
    .cmd_valid_i(pop_valid),
    .cmd_ready_o(pop_ready),
    .cmd_i      (pop_cmd),
    .out_o      (out_o)
  );

endmodule

/* hdl/bmm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bmm_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bmm_front.sv */
// Front end: accepts input items, drops out-of-range ones, forwards commands.
// Depends on bmm_pkg and the bmm_in_if interface.
module bmm_front (
  bmm_in_if.sink              in_i,
  input  bmm_pkg::cfg_t       cfg_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output bmm_pkg::cmd_t       push_cmd_o
);

  logic                      keep;
  logic [bmm_pkg::IDX_W-1:0] bsz_ext;
  logic [bmm_pkg::DIM_W-1:0] row_ext;
  logic [bmm_pkg::DIM_W-1:0] col_ext;
  bmm_pkg::cmd_e             kind;

  assign bsz_ext = {1'b0, cfg_i.bsz};
  assign row_ext = {1'b0, in_i.row_index};
  assign col_ext = {1'b0, in_i.col_index};

  // A load must land inside the current band; a row command must name a row of it.
  always_comb begin
    keep = 1'b0;
    kind = bmm_pkg::CMD_ROW;
    case (in_i.opcode)
      bmm_pkg::OP_WR_A: begin
        kind = bmm_pkg::CMD_WR_A;
        keep = (in_i.row_index < bsz_ext) && (col_ext < cfg_i.dim);
      end
      bmm_pkg::OP_WR_B: begin
        kind = bmm_pkg::CMD_WR_B;
        keep = (row_ext < cfg_i.dim) && (in_i.col_index < bsz_ext);
      end
      bmm_pkg::OP_ROW: begin
        kind = bmm_pkg::CMD_ROW;
        keep = in_i.row_index < bsz_ext;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_i.ready        = push_ready_i;
  assign push_valid_o      = in_i.valid && keep;
  assign push_cmd_o.kind   = kind;
  assign push_cmd_o.row    = in_i.row_index;
  assign push_cmd_o.col    = in_i.col_index;
  assign push_cmd_o.value  = in_i.value;

endmodule

/* hdl/bmm_queue.sv */
// Small command queue between the front end and the back end.
// Depends on bmm_pkg.
module bmm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  bmm_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output bmm_pkg::cmd_t pop_cmd_o
);

  bmm_pkg::cmd_t                   mem_q [bmm_pkg::QUEUE_DEPTH];
  logic [bmm_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [bmm_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [bmm_pkg::QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                            push;
  logic                            pop;

  assign push_ready_o = cnt_q != bmm_pkg::QUEUE_CNT_W'(bmm_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* hdl/bmm_back.sv */
// Back end: band stores, multiply-accumulate sequencer and result register.
// Depends on bmm_pkg, bmm_ram and the bmm_out_if interface.
module bmm_back #(
  parameter int unsigned MAX_DIM   = 64,
  parameter int unsigned MAX_BLOCK = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bmm_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  bmm_pkg::cmd_t cmd_i,
  bmm_out_if.source     out_o
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_BLOCK;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W  = bmm_pkg::PROD_W + 1 + $clog2(MAX_DIM);
  localparam int unsigned RND_W  = ACC_W - bmm_pkg::Q_FRAC;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (bmm_pkg::Q_FRAC - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_ROUND,
    S_OUT
  } state_e;

  state_e                       state_q, state_d;
  logic [bmm_pkg::IDX_W-1:0]    row_q, row_d;
  logic [bmm_pkg::BSZ_W-1:0]    j_q, j_d;
  logic [bmm_pkg::DIM_W-1:0]    k_q, k_d;
  logic                         rd_vld_q, rd_vld_d;
  logic                         prod_vld_q;
  logic signed [bmm_pkg::PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [ACC_W-1:0]      acc_rnd;
  logic signed [RND_W-1:0]      rnd_q;
  logic                         acc_clr;
  logic                         out_load;
  logic                         last_col;

  logic                         a_we, b_we;
  logic [ADDR_W-1:0]            a_waddr, b_waddr, a_raddr, b_raddr;
  logic [bmm_pkg::VALUE_W-1:0]  a_rdata, b_rdata;

  logic                         out_vld_q;
  logic [bmm_pkg::OUT_IDX_W-1:0] out_row_q, out_col_q;
  logic [bmm_pkg::VALUE_W-1:0]  out_prod_q, out_prod_d;
  logic                         out_sat_q, out_sat_d;
  logic                         out_last_q;
  logic                         fits;

  // Band addresses use the fixed strides MAX_DIM and MAX_BLOCK.
  assign a_waddr = ADDR_W'(int'(cmd_i.row) * MAX_DIM + int'(cmd_i.col));
  assign b_waddr = ADDR_W'(int'(cmd_i.row) * MAX_BLOCK + int'(cmd_i.col));
  assign a_raddr = ADDR_W'(int'(row_q) * MAX_DIM + int'(k_q));
  assign b_raddr = ADDR_W'(int'(k_q) * MAX_BLOCK + int'(j_q));

  bmm_ram #(
    .WIDTH (bmm_pkg::VALUE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_a_band (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(cmd_i.value),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  bmm_ram #(
    .WIDTH (bmm_pkg::VALUE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_b_band (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(cmd_i.value),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  assign last_col = j_q == (cfg_i.bsz - 1'b1);
  assign acc_rnd  = acc_q + ROUND_HALF;

  // The rounded sum fits when every bit from 31 up equals the sign bit.
  assign fits = (&rnd_q[RND_W-1:bmm_pkg::VALUE_W-1]) || !(|rnd_q[RND_W-1:bmm_pkg::VALUE_W-1]);

  always_comb begin
    if (fits) begin
      out_prod_d = rnd_q[bmm_pkg::VALUE_W-1:0];
      out_sat_d  = 1'b0;
    end else if (rnd_q[RND_W-1]) begin
      out_prod_d = {1'b1, {(bmm_pkg::VALUE_W-1){1'b0}}};
      out_sat_d  = 1'b1;
    end else begin
      out_prod_d = {1'b0, {(bmm_pkg::VALUE_W-1){1'b1}}};
      out_sat_d  = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    j_d         = j_q;
    k_d         = k_q;
    rd_vld_d    = 1'b0;
    acc_clr     = 1'b0;
    a_we        = 1'b0;
    b_we        = 1'b0;
    cmd_ready_o = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            bmm_pkg::CMD_WR_A: a_we = 1'b1;
            bmm_pkg::CMD_WR_B: b_we = 1'b1;
            bmm_pkg::CMD_ROW: begin
              row_d   = cmd_i.row;
              j_d     = '0;
              k_d     = '0;
              acc_clr = 1'b1;
              state_d = (cfg_i.dim == '0) ? S_DRAIN : S_ISSUE;
            end
            default: ;
          endcase
        end
      end
      S_ISSUE: begin
        rd_vld_d = 1'b1;
        k_d      = k_q + 1'b1;
        if (k_q == (cfg_i.dim - 1'b1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: state_d = S_OUT;
      S_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          acc_clr  = 1'b1;
          k_d      = '0;
          j_d      = j_q + 1'b1;
          if (last_col) begin
            state_d = S_IDLE;
          end else begin
            state_d = (cfg_i.dim == '0) ? S_DRAIN : S_ISSUE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_vld_d;
      prod_vld_q <= rd_vld_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    j_q    <= j_d;
    k_q    <= k_d;
    prod_q <= $signed(a_rdata) * $signed(b_rdata);
    if (acc_clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    rnd_q <= acc_rnd[ACC_W-1:bmm_pkg::Q_FRAC];
    if (out_load) begin
      out_row_q  <= row_q[bmm_pkg::OUT_IDX_W-1:0];
      out_col_q  <= j_q[bmm_pkg::OUT_IDX_W-1:0];
      out_prod_q <= out_prod_d;
      out_sat_q  <= out_sat_d;
      out_last_q <= last_col;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.block_row = out_row_q;
  assign out_o.block_col = out_col_q;
  assign out_o.product   = out_prod_q;
  assign out_o.saturated = out_sat_q;
  assign out_o.last      = out_last_q;

endmodule

/* hdl/bmm_checker.sv */
// Port-level checker of the block matrix multiply core, bound to the top level.
// Depends on block_matrix_multiply_core_defines.svh.
`include "block_matrix_multiply_core_defines.svh"

module bmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_product_i,
  input logic [3:0]  out_block_col_i,
  input logic        out_saturated_i,
  input logic        out_last_i
);

  // A waiting result keeps its product, column and last flag until it is taken.
  `BMM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_product_i) && $stable(out_block_col_i) && $stable(out_last_i), "result changed while stalled")

  // A clipped result sits at one of the two rails.
  `BMM_ASSERT_IMPLY(a_sat_rail, clk_i, rst_ni, out_valid_i && out_saturated_i, out_product_i == 32'h7fffffff || out_product_i == 32'h80000000, "saturated result not at a rail")

  // Nothing is offered in the first cycle after reset.
  `BMM_ASSERT_IMPLY(a_reset_quiet, clk_i, rst_ni, $rose(rst_ni), !out_valid_i, "result valid right after reset")

endmodule

bind block_matrix_multiply_core bmm_checker u_bmm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_product_i  (out_o.product),
  .out_block_col_i(out_o.block_col),
  .out_saturated_i(out_o.saturated),
  .out_last_i     (out_o.last)
);
